/* design/tcc_pkg.sv */
// types, codes and constants shared by the text console cursor blocks
package tcc_pkg;

  // cursor position, pixel, screen dimension, cell and character widths
  localparam int unsigned POS_W  = 10;
  localparam int unsigned PROD_W = 18;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned CELL_W = 7;
  localparam int unsigned CHAR_W = 8;

  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

  // control bytes
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;

  typedef enum logic {
    FUNC_PUT = 1'b0,
    FUNC_SET = 1'b1
  } tcc_func_e;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_SCROLL = 1'b1
  } tcc_cmd_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CELL_WIDTH    = 2'd2,
    REG_CELL_HEIGHT   = 2'd3
  } tcc_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
  } tcc_cfg_t;

  typedef struct packed {
    tcc_func_e         func;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  set_col;
    logic [POS_W-1:0]  set_row;
  } tcc_item_t;

  typedef struct packed {
    tcc_cmd_e          command;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic [CHAR_W-1:0] glyph_code;
    logic              last;
  } tcc_res_t;

  // up to two result words produced by one item, in order
  typedef struct packed {
    logic [1:0] count;
    tcc_res_t   first;
    tcc_res_t   second;
  } tcc_push_t;

endpackage

/* design/tcc_in_if.sv */
// input channel: put character or set cursor request
interface tcc_in_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  set_col;
  logic [POS_W-1:0]  set_row;

  modport source (output valid, output func, output char_code, output set_col,
                  output set_row, input ready);
  modport sink (input valid, input func, input char_code, input set_col,
                input set_row, output ready);
endinterface

/* design/tcc_out_if.sv */
// output channel: draw and scroll commands
interface tcc_out_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [CHAR_W-1:0] glyph_code;
  logic              last;

  modport source (output valid, output command, output pixel_x, output pixel_y,
                  output glyph_code, output last, input ready);
  modport sink (input valid, input command, input pixel_x, input pixel_y,
                input glyph_code, input last, output ready);
endinterface

/* design/tcc_result_fifo.sv */
// small result queue taking up to two words a cycle and giving one while the output is ready
module tcc_result_fifo
  import tcc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcc_push_t        push_i,
  output logic             room_o,
  tcc_out_if.source        out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tcc_res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // head word and space flag
  assign pop             = out_o.valid && out_o.ready;
  assign room_o          = cnt_q <= CntW'(Depth - 2);
  assign out_o.valid     = cnt_q != '0;
  assign out_o.command   = mem_q[rd_ptr_q].command;
  assign out_o.pixel_x   = mem_q[rd_ptr_q].pixel_x;
  assign out_o.pixel_y   = mem_q[rd_ptr_q].pixel_y;
  assign out_o.glyph_code = mem_q[rd_ptr_q].glyph_code;
  assign out_o.last      = mem_q[rd_ptr_q].last;

  // pointer and fill count update
  always_comb begin
    wr_nxt   = ptr_inc(wr_ptr_q);
    wr_ptr_d = wr_ptr_q;
    if (push_i.count == 2'd1) begin
      wr_ptr_d = wr_nxt;
    end else if (push_i.count == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_nxt);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

endmodule

/* design/tcc_cursor_core.sv */
// cursor state, pixel products, commands; one item a cycle unless stalled
module tcc_cursor_core
  import tcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tcc_cfg_t  cfg_i,
  input  logic      cfg_we_i,
  input  logic      item_valid_i,
  input  tcc_item_t item_i,
  input  logic      room_i,
  output logic      take_o,
  output tcc_push_t push_o
);

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [PROD_W-1:0] prod;
  } pos_prod_t;

  // cursor and its pixel products (col * cell_width, row * cell_height)
  logic [POS_W-1:0]  col_q, row_q;
  logic [PROD_W-1:0] colw_q, rowh_q;
  logic              recalc_q;

  pos_prod_t c0, c1, c2, c_n, r0, r1, r_s, r_n;
  logic [PROD_W-1:0] cwp, chp, swp, shp, rmax;
  logic [PROD_W-1:0] mul_col, mul_row;
  logic              wrap, draw, chk, scroll;
  tcc_res_t          draw_res, scroll_res;

  function automatic pos_prod_t pos_inc(pos_prod_t cur, logic [2:0] step,
                                        logic [PROD_W-1:0] step_prod,
                                        logic [PROD_W-1:0] max_prod);
    logic [POS_W:0] sum;
    pos_prod_t      res;
    sum = {1'b0, cur.pos} + (POS_W+1)'(step);
    if (sum >= {1'b0, POS_MAX}) begin
      res.pos  = POS_MAX;
      res.prod = max_prod;
    end else begin
      res.pos  = sum[POS_W-1:0];
      res.prod = cur.prod + step_prod;
    end
    pos_inc = res;
  endfunction

  function automatic logic [PIX_W-1:0] pix_sat(logic [PROD_W-1:0] v);
    pix_sat = (v > PROD_W'(PIX_MAX)) ? PIX_MAX : v[PIX_W-1:0];
  endfunction

  assign cwp  = PROD_W'(cfg_i.cell_width);
  assign chp  = PROD_W'(cfg_i.cell_height);
  assign swp  = PROD_W'(cfg_i.screen_width);
  assign shp  = PROD_W'(cfg_i.screen_height);
  assign rmax = (chp << POS_W) - chp;

  assign take_o = item_valid_i && !recalc_q && room_i;

  // shared multiplier: set cursor request, or rebuild after a register write
  always_comb begin
    if (recalc_q) begin
      mul_col = PROD_W'(col_q) * cwp;
      mul_row = PROD_W'(row_q) * chp;
    end else begin
      mul_col = PROD_W'(item_i.set_col) * cwp;
      mul_row = PROD_W'(item_i.set_row) * chp;
    end
  end

  // put character: wrap, control codes, advance and scroll check
  always_comb begin
    c0.pos  = col_q;
    c0.prod = colw_q;
    r0.pos  = row_q;
    r0.prod = rowh_q;
    wrap    = c0.prod >= swp;
    c1      = wrap ? '0 : c0;
    r1      = wrap ? pos_inc(r0, 3'd1, chp, rmax) : r0;
    c2      = c1;
    c_n     = c1;
    r_s     = r1;
    draw    = 1'b0;
    chk     = 1'b0;
    unique case (item_i.char_code)
      CHAR_NEWLINE: begin
        c_n = '0;
        r_s = pos_inc(r1, 3'd1, chp, rmax);
        chk = 1'b1;
      end
      CHAR_BACKSPACE: begin
        if (c1.pos != '0) begin
          c_n.pos  = c1.pos - POS_W'(1);
          c_n.prod = c1.prod - cwp;
        end
      end
      CHAR_RETURN: begin
        c_n = '0;
      end
      CHAR_TAB: begin
        r_s = pos_inc(r1, 3'd4, chp << 2, rmax);
      end
      default: begin
        draw = 1'b1;
        chk  = 1'b1;
        if (c1.pos != POS_MAX) begin
          c2.pos  = c1.pos + POS_W'(1);
          c2.prod = c1.prod + cwp;
        end
        // next cell would not fit: wrap now
        if (c2.prod + cwp >= swp) begin
          c_n = '0;
          r_s = pos_inc(r1, 3'd1, chp, rmax);
        end else begin
          c_n = c2;
        end
      end
    endcase

    // bottom reached: scroll up one row
    scroll = chk && (r_s.prod + chp >= shp);
    r_n    = r_s;
    if (scroll && r_s.pos != '0) begin
      r_n.pos  = r_s.pos - POS_W'(1);
      r_n.prod = r_s.prod - chp;
    end
  end

  // result words
  always_comb begin
    draw_res.command    = CMD_DRAW;
    draw_res.pixel_x    = pix_sat(c1.prod);
    draw_res.pixel_y    = pix_sat(r1.prod);
    draw_res.glyph_code = item_i.char_code;
    draw_res.last       = !scroll;

    scroll_res.command    = CMD_SCROLL;
    scroll_res.pixel_x    = '0;
    scroll_res.pixel_y    = '0;
    scroll_res.glyph_code = '0;
    scroll_res.last       = 1'b1;

    push_o.first  = draw ? draw_res : scroll_res;
    push_o.second = scroll_res;
    push_o.count  = '0;
    if (take_o && item_i.func == FUNC_PUT) begin
      push_o.count = 2'(draw) + 2'(scroll);
    end
  end

  // cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      colw_q   <= '0;
      rowh_q   <= '0;
      recalc_q <= 1'b0;
    end else begin
      recalc_q <= cfg_we_i;
      if (recalc_q) begin
        colw_q <= mul_col;
        rowh_q <= mul_row;
      end else if (take_o) begin
        if (item_i.func == FUNC_SET) begin
          col_q  <= item_i.set_col;
          row_q  <= item_i.set_row;
          colw_q <= mul_col;
          rowh_q <= mul_row;
        end else begin
          col_q  <= c_n.pos;
          row_q  <= r_n.pos;
          colw_q <= c_n.prod;
          rowh_q <= r_n.prod;
        end
      end
    end
  end

  a_colw_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recalc_q |-> colw_q == PROD_W'(col_q) * cwp)
    else $error("column pixel product out of step with column");

  a_rowh_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recalc_q |-> rowh_q == PROD_W'(row_q) * chp)
    else $error("row pixel product out of step with row");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |->
      push_o.first.command == CMD_DRAW && push_o.second.command == CMD_SCROLL)
    else $error("two words per item must be draw then scroll");

endmodule

/* design/text_console_cursor_control.sv */
// top level of the text console cursor control
//
//  port      dir  handshake          word
//  in_i      in   valid/ready        func, char_code, set_col, set_row
//  out_o     out  valid/ready        command, pixel_x, pixel_y, glyph_code, last
//  cfg_*     in   cfg_we_i, no wait  cfg_idx_i selects register, cfg_data_i
//
// An item is registered in the input register, then handled by the cursor
// core, which pushes zero, one or two words into the result queue.
// Sustained rate: one item a cycle while the output is ready; for items
// giving two words the single output port sets the rate.
// After a register write the cursor pixel products are rebuilt in the
// next cycle, in which no item is taken.
// Reset: cursor at column 0, row 0; registers 1024, 768, 10 and 20.
// A stalled output fills the queue until two words no longer fit, then holds the input register.
module text_console_cursor_control
  import tcc_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcc_in_if.sink                in_i,
  tcc_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [DIM_W-1:0]      cfg_data_i
);

  tcc_cfg_t  cfg_q;
  tcc_item_t item_q;
  logic      item_vld_q;
  logic      take, room;
  tcc_push_t push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 13'd1024;
      cfg_q.screen_height <= 13'd768;
      cfg_q.cell_width    <= 7'd10;
      cfg_q.cell_height   <= 7'd20;
    end else if (cfg_we_i) begin
      unique case (tcc_reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        REG_CELL_WIDTH:    cfg_q.cell_width    <= cfg_data_i[CELL_W-1:0];
        REG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data_i[CELL_W-1:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // input register
  assign in_i.ready = !item_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func      <= tcc_func_e'(in_i.func);
      item_q.char_code <= in_i.char_code;
      item_q.set_col   <= in_i.set_col;
      item_q.set_row   <= in_i.set_row;
    end
  end

  tcc_cursor_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_we_i     (cfg_we_i),
    .item_valid_i (item_vld_q),
    .item_i       (item_q),
    .room_i       (room),
    .take_o       (take),
    .push_o       (push)
  );

  tcc_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
